### rtl/signed_int_to_decimal_ascii_core_macros.svh
// assertion macros used by the port-level checker
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SIDA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sida_pkg.sv
// shared constants and types for the signed integer to decimal text block
package sida_pkg;

   localparam int VALUE_W     = 32;
   localparam int DIGITS      = 10;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SHIFT_CNT_W = $clog2(VALUE_W);
   localparam int DIGIT_IDX_W = $clog2(DIGITS);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } mag_entry_type;

   typedef struct packed {
      logic    neg;
      bcd_type bcd;
   } conv_result_type;

   typedef enum logic [1:0] {
      CVT_IDLE,
      CVT_SHIFT,
      CVT_HOLD
   } cvt_state_type;

endpackage

### rtl/sida_front.sv
// front end: takes values, splits sign and magnitude, queues them for conversion
module sida_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output sida_pkg::mag_entry_type       q_entry,
   output logic                          q_empty,
   input  logic                          q_pop
);

   sida_pkg::mag_entry_type queue_ff [sida_pkg::QUEUE_DEPTH];

   logic [sida_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sida_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sida_pkg::QCNT_W-1:0] count_ff,  count_in;

   logic [sida_pkg::VALUE_W-1:0] raw;
   sida_pkg::mag_entry_type      entry;
   logic                         push_ok;
   logic                         pop_ok;

   // sign and magnitude; the most negative value maps to 2^31, which fits unsigned
   assign raw       = req_value;
   assign entry.neg = raw[sida_pkg::VALUE_W-1];
   assign entry.mag = entry.neg ? (~raw + sida_pkg::VALUE_W'(1)) : raw;

   assign req_full = (count_ff == sida_pkg::QCNT_W'(sida_pkg::QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign q_entry  = queue_ff[rd_ptr_ff];

   assign push_ok = req_push && !req_full;
   assign pop_ok  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == sida_pkg::QPTR_W'(sida_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sida_pkg::QPTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == sida_pkg::QPTR_W'(sida_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sida_pkg::QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + sida_pkg::QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - sida_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/sida_convert.sv
// back end, first half: bit-serial binary to bcd conversion (shift and add 3)
module sida_convert (
   input  logic                      clock,
   input  logic                      reset,
   input  sida_pkg::mag_entry_type   q_entry,
   input  logic                      q_empty,
   output logic                      q_pop,
   output sida_pkg::conv_result_type res,
   output logic                      res_valid,
   input  logic                      res_ready
);

   sida_pkg::cvt_state_type state_ff, state_in;

   logic [sida_pkg::VALUE_W-1:0]     mag_ff;
   logic                             neg_ff;
   sida_pkg::bcd_type                bcd_ff, bcd_adj, bcd_in;
   logic [sida_pkg::DIGITS*sida_pkg::DIGIT_W-1:0] adj_flat;
   logic [sida_pkg::SHIFT_CNT_W-1:0] cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sida_pkg::CVT_IDLE: begin
            if (!q_empty) state_in = sida_pkg::CVT_SHIFT;
         end
         sida_pkg::CVT_SHIFT: begin
            if (cnt_ff == sida_pkg::SHIFT_CNT_W'(sida_pkg::VALUE_W - 1)) begin
               state_in = sida_pkg::CVT_HOLD;
            end
         end
         sida_pkg::CVT_HOLD: begin
            if (res_ready) state_in = sida_pkg::CVT_IDLE;
         end
         default: state_in = sida_pkg::CVT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         sida_pkg::CVT_IDLE:  q_pop     = !q_empty;
         sida_pkg::CVT_SHIFT: q_pop     = 1'b0;
         sida_pkg::CVT_HOLD:  res_valid = 1'b1;
         default: begin
            q_pop     = 1'b0;
            res_valid = 1'b0;
         end
      endcase
   end

   // one shift step: digits of 5 or more get 3 added, then everything moves left
   always_comb begin
      for (int i = 0; i < sida_pkg::DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= sida_pkg::DIGIT_W'(5)) ?
                      bcd_ff[i] + sida_pkg::DIGIT_W'(3) : bcd_ff[i];
      end
      adj_flat = bcd_adj;
      bcd_in   = {adj_flat[sida_pkg::DIGITS*sida_pkg::DIGIT_W-2:0],
                  mag_ff[sida_pkg::VALUE_W-1]};
   end

   assign res.neg = neg_ff;
   assign res.bcd = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::CVT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mag_ff <= q_entry.mag;
         neg_ff <= q_entry.neg;
         bcd_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == sida_pkg::CVT_SHIFT) begin
         bcd_ff <= bcd_in;
         mag_ff <= {mag_ff[sida_pkg::VALUE_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + sida_pkg::SHIFT_CNT_W'(1);
      end
   end

endmodule

### rtl/sida_emit.sv
// back end, second half: holds one converted number and sends its characters
module sida_emit (
   input  logic                               clock,
   input  logic                               reset,
   input  sida_pkg::conv_result_type          res,
   input  logic                               res_valid,
   output logic                               res_ready,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sida_pkg::CHAR_W-1:0]        rsp_character,
   output logic                               rsp_last
);

   logic                             valid_ff;
   logic                             sign_ff;
   sida_pkg::bcd_type                bcd_ff;
   logic [sida_pkg::DIGIT_IDX_W-1:0] idx_ff;

   logic [sida_pkg::DIGIT_IDX_W-1:0] top_idx;
   logic                             pop_ok;
   logic                             load;

   // most significant nonzero digit; zero still prints one digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < sida_pkg::DIGITS; i++) begin
         if (res.bcd[i] != '0) top_idx = sida_pkg::DIGIT_IDX_W'(i);
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_last      = !sign_ff && (idx_ff == '0);
   assign rsp_character = sign_ff ? sida_pkg::CHAR_MINUS :
                          sida_pkg::CHAR_ZERO +
                          {{(sida_pkg::CHAR_W - sida_pkg::DIGIT_W){1'b0}}, bcd_ff[idx_ff]};

   assign pop_ok    = rsp_pop && valid_ff;
   assign res_ready = !valid_ff || (pop_ok && rsp_last);
   assign load      = res_valid && res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (pop_ok && rsp_last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sign_ff <= res.neg;
         bcd_ff  <= res.bcd;
         idx_ff  <= top_idx;
      end else if (pop_ok) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else if (idx_ff != '0) begin
            idx_ff <= idx_ff - sida_pkg::DIGIT_IDX_W'(1);
         end
      end
   end

endmodule

### rtl/signed_int_to_decimal_ascii_core.sv
// top level of the signed 32-bit integer to decimal ascii text converter
// Each 32-bit two's complement value pushed in comes out as its decimal text, one
// ascii character per beat, most significant first: '-' first for negative values,
// no leading zeros, a lone '0' for zero, and rsp_last set on the final character
// (1 to 11 beats per number; the most negative value gives eleven). Both sides
// behave as queues: push while req_full is low, pop while rsp_empty is low.
// Inside, a front end splits sign and magnitude into a two-entry queue, a
// shift-and-add-3 binary to bcd converter takes one magnitude bit per cycle, and
// an emitter holds one finished number and sends its characters. A number passes
// through the converter as a load from the queue, one shift step per magnitude bit
// and a handoff to the emitter; the bit-serial converter takes the next number only
// after that handoff and so sets the sustained rate. Emission of one number overlaps
// conversion of the next.
module signed_int_to_decimal_ascii_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sida_pkg::CHAR_W-1:0]        rsp_character,
   output logic                               rsp_last
);

   // front end to converter
   sida_pkg::mag_entry_type   q_entry;
   logic                      q_empty;
   logic                      q_pop;

   // converter to emitter
   sida_pkg::conv_result_type res;
   logic                      res_valid;
   logic                      res_ready;

   // sign/magnitude split plus a short queue so pushes wait on conversion only when it is full
   sida_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_entry   (q_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop)
   );

   // one magnitude bit per cycle into ten bcd digits
   sida_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (q_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .res       (res),
      .res_valid (res_valid),
      .res_ready (res_ready)
   );

   // registered output: one character beat per pop, next number loads on the last beat
   sida_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .res           (res),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### rtl/sida_checker.sv
// port-level checker for the converter, bound to the top level
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sida_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [sida_pkg::CHAR_W-1:0] rsp_character,
   input logic                        rsp_last
);

   logic is_minus;
   logic is_digit;

   assign is_minus = (rsp_character == sida_pkg::CHAR_MINUS);
   assign is_digit = (rsp_character >= sida_pkg::CHAR_ZERO) &&
                     (rsp_character <= sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(9));

   // a waiting beat holds until popped
   `SIDA_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_character) && $stable(rsp_last), "rsp beat changed while waiting")

   // only a sign or a decimal digit ever shows
   `SIDA_ASSERT_NOW(a_char_set, !rsp_empty, is_minus || is_digit, "rsp character outside sign and digits")

   // the sign never ends a number
   `SIDA_ASSERT_NOW(a_sign_not_last, !rsp_empty && is_minus, !rsp_last, "sign beat marked last")

   // a digit follows the sign at once
   `SIDA_ASSERT_NEXT(a_digit_after_sign, !rsp_empty && rsp_pop && is_minus, !rsp_empty && is_digit, "no digit right after sign")

endmodule

bind signed_int_to_decimal_ascii_core sida_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

### dv/testbench.sv
// self-checking testbench for the signed integer to decimal ascii text converter
`timescale 1ns / 100ps

module testbench;

   // cycles without any accepted beat before the run is declared hung;
   // the receiver hold-off below plus a full conversion fits well inside
   localparam int STALL_LIMIT    = 3000;
   localparam int HOLD_OFF_LEN   = 400;   // receiver hold-off stretch, in cycles
   localparam int HOLD_OFF_AT    = 60;    // hold-off starts once this many values went in
   localparam int RANDOM_VALUES  = 348;
   localparam int BUSY_FROM      = 150;   // random values in this window run with no idling
   localparam int BUSY_TO        = 230;
   localparam int IDLE_PCT       = 21;
   localparam int DRAIN_CYCLES   = 60;    // quiet time after the last expected character

   typedef struct {
      logic [sida_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   // predicts the text of every accepted value and checks characters in order
   class decimal_text_scoreboard;
      text_char_type expected_chars[$];
      int            mismatches;
      int            values_noted;

      function new();
         mismatches   = 0;
         values_noted = 0;
      endfunction

      // split into sign and 32-bit magnitude, then digits most significant first
      function void note_value(logic signed [sida_pkg::VALUE_W-1:0] value);
         logic                         neg;
         logic [sida_pkg::VALUE_W-1:0] mag;
         logic [3:0]                   digits[sida_pkg::DIGITS];
         int                           count;
         text_char_type                entry;
         neg   = value[sida_pkg::VALUE_W-1];
         // the most negative value wraps to 2^31, which fits unsigned
         mag   = neg ? (~value + 1'b1) : value;
         count = 0;
         do begin
            digits[count] = 4'(mag % 10);
            mag           = mag / 10;
            count++;
         end while (mag != 0);
         if (neg) begin
            entry.character = sida_pkg::CHAR_MINUS;
            entry.last      = 1'b0;
            expected_chars.push_back(entry);
         end
         for (int k = count - 1; k >= 0; k--) begin
            entry.character = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digits[k]);
            entry.last      = (k == 0);
            expected_chars.push_back(entry);
         end
         values_noted++;
      endfunction

      function void check_character(logic [sida_pkg::CHAR_W-1:0] character, logic last);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected character beat: character %h last %b", character, last);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (character !== want.character) begin
            $error("character: expected %h actual %h", want.character, character);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %b actual %b", want.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic signed [sida_pkg::VALUE_W-1:0] req_value;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic [sida_pkg::CHAR_W-1:0]         rsp_character;
   logic                                rsp_last;

   // set by the stimulus sequence, read by both sides: a stretch with no idling
   logic                      no_idle;

   decimal_text_scoreboard    text_sb;

   signed_int_to_decimal_ascii_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // random value spread over digit counts and both signs, with plenty of
   // raw bit patterns so every input bit is seen at both levels
   function automatic logic signed [sida_pkg::VALUE_W-1:0] random_value();
      int unsigned                  pick;
      int unsigned                  ndig;
      longint unsigned              limit;
      logic [sida_pkg::VALUE_W-1:0] mag;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         return $urandom;
      end else if (pick < 38) begin
         case ($urandom_range(0, 4))
            0: return 32'sh0000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      ndig = $urandom_range(1, 10);
      if (ndig == 10) begin
         mag = $urandom_range(1000000000, 2147483647);
      end else begin
         limit = 1;
         repeat (ndig) limit = limit * 10;
         mag = sida_pkg::VALUE_W'($urandom % limit);
      end
      return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
   endfunction

   // offer one value, with random idle cycles ahead of it, and hold it
   // until the block takes it
   task automatic push_value(logic signed [sida_pkg::VALUE_W-1:0] value);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      text_sb.note_value(value);
   endtask

   // sender stops offering until every expected character has come out
   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (text_sb.pending() != 0) @(posedge clock);
   endtask

   // result side: check every popped beat, pop at random, and once hold off
   // for a long stretch so the front queue fills and req_full rises
   initial begin : result_side
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            text_sb.check_character(rsp_character, rsp_last);
         end
         if (!hold_done && text_sb.values_noted >= HOLD_OFF_AT) begin
            hold_done = 1;
            hold_left = HOLD_OFF_LEN;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // hang detector: counts cycles with no beat taken on either side
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic signed [sida_pkg::VALUE_W-1:0] directed[$];
      text_sb   = new();
      reset     = 1'b1;
      req_push  = 1'b0;
      req_value = '0;
      no_idle   = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, unit values, digit boundaries, the positive extreme, the most
      // negative value (eleven characters) and alternating bit patterns
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                   32'sd100, -32'sd5, 32'sd1000, -32'sd100000, 32'sd999999999,
                   32'sd1000000000, -32'sd999999999, 32'sd1234567890,
                   -32'sd1234567890, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA};
      foreach (directed[i]) push_value(directed[i]);

      // empty the block completely before the random part
      wait_for_drain();

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         no_idle <= (n >= BUSY_FROM && n < BUSY_TO);
         if (n == BUSY_TO + 20) begin
            wait_for_drain();
         end
         push_value(random_value());
      end
      req_push <= 1'b0;
      no_idle  <= 1'b0;

      // let the tail drain, then look for stray beats a while longer
      while (text_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/sida_pkg.sv
rtl/sida_front.sv
rtl/sida_convert.sv
rtl/sida_emit.sv
rtl/signed_int_to_decimal_ascii_core.sv
rtl/sida_checker.sv
dv/testbench.sv
